FILE: hdl/esb_pkg.sv
// Shared types and constants for the EDF slack packet buffer.
// Used by the controller, the datapath and the top level.
package esb_pkg;

	localparam int unsigned DEPTH_DEFAULT = 64;
	localparam logic [6:0]  CAP_RESET     = 7'd64;
	localparam int unsigned ENTRY_W       = 24;

	localparam logic        OP_ARRIVE = 1'b0;
	localparam logic        OP_TICK   = 1'b1;

	localparam logic        REG_CAPACITY = 1'b0;

	typedef enum logic [1:0] {
		PASS_MIN  = 2'd0,
		PASS_ROT  = 2'd1,
		PASS_TICK = 2'd2
	} pass_mode_t;

	typedef struct packed {
		logic load;
		logic take;
		logic drop;
		logic put;
		logic start_min;
		logic start_rot;
		logic start_tick;
		logic send;
		logic emit;
	} esb_cmd_t;

	typedef struct packed {
		logic busy;
		logic rem_zero;
		logic room;
		logic occ_zero;
		logic is_tick;
		logic out_free;
	} esb_sts_t;

endpackage

FILE: hdl/edf_slack_packet_buffer_unit.sv
// Top level of the EDF slack packet buffer: APB capacity register, ctrl, datapath.
// Depends on esb_pkg, esb_ctrl, esb_dp (and esb_ram below it).
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  in      | sink      | in_valid / in_stall | operation, packet_count, arrival_slack,
//          |           |                     | packet_worth
//  out     | source    | out_valid/out_stall | dropped_now, sent_*, total_*
//  cfg     | APB slave | psel/penable/pready | capacity at byte address 0
//
// One item at a time. An arriving packet that fits is appended directly; a replacement
// costs a min scan plus a removal copy. A tick costs one expiry pass and, if entries
// remain, one removal copy. The passes read one entry a cycle from the live RAM bank;
// the copy passes write the compacted list to the other.
// Reset clears occupancy, the running sums and out_valid; RAM contents and the
// result fields are left as they are. A result waits in the output register while
// out_stall is high; the next item is taken then, but its result holds until the register frees.
module edf_slack_packet_buffer_unit import esb_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [7:0]  packet_count,
	input  logic [7:0]  arrival_slack,
	input  logic [15:0] packet_worth,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  dropped_now,
	output logic        sent_valid,
	output logic [15:0] sent_worth,
	output logic [31:0] total_arrived,
	output logic [31:0] total_dropped,
	output logic [31:0] total_sent,
	output logic [31:0] total_worth,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	esb_cmd_t   cmd;
	esb_sts_t   sts;
	logic [6:0] capacity_q;

	// Capacity register: word-aligned, one word.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CAPACITY) ? {25'd0, capacity_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
			capacity_q <= pwdata[6:0];
		end
	end

	esb_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .sts, .cmd
	);

	esb_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.operation, .packet_count, .arrival_slack, .packet_worth,
		.capacity(capacity_q),
		.out_valid, .out_stall, .dropped_now, .sent_valid, .sent_worth,
		.total_arrived, .total_dropped, .total_sent, .total_worth
	);
endmodule

FILE: hdl/esb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module esb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: hdl/esb_ctrl.sv
// Controller state machine of the EDF slack packet buffer.
// Depends on esb_pkg; drives commands into esb_dp.
module esb_ctrl import esb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  esb_sts_t sts,
	output esb_cmd_t cmd
);
	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_ARR_NEXT = 8'b0000_0010,
		ST_ARR_MIN  = 8'b0000_0100,
		ST_ARR_ROT  = 8'b0000_1000,
		ST_TICK_GO  = 8'b0001_0000,
		ST_TICK_WT  = 8'b0010_0000,
		ST_TICK_ROT = 8'b0100_0000,
		ST_FINISH   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_ARR_NEXT;
				end
			end
			ST_ARR_NEXT: begin
				if (sts.is_tick) begin
					state_d = ST_TICK_GO;
				end else if (sts.rem_zero) begin
					state_d = ST_FINISH;
				end else if (sts.room) begin
					cmd.put  = 1'b1;
					cmd.take = 1'b1;
				end else begin
					cmd.take = 1'b1;
					cmd.drop = 1'b1;
					if (!sts.occ_zero) begin
						cmd.start_min = 1'b1;
						state_d       = ST_ARR_MIN;
					end
				end
			end
			ST_ARR_MIN: begin
				if (!sts.busy) begin
					cmd.start_rot = 1'b1;
					state_d       = ST_ARR_ROT;
				end
			end
			ST_ARR_ROT: begin
				if (!sts.busy) begin
					cmd.put = 1'b1;
					state_d = ST_ARR_NEXT;
				end
			end
			ST_TICK_GO: begin
				cmd.start_tick = 1'b1;
				state_d        = ST_TICK_WT;
			end
			ST_TICK_WT: begin
				if (!sts.busy) begin
					if (sts.occ_zero) begin
						state_d = ST_FINISH;
					end else begin
						cmd.send      = 1'b1;
						cmd.start_rot = 1'b1;
						state_d       = ST_TICK_ROT;
					end
				end
			end
			ST_TICK_ROT: begin
				if (!sts.busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

FILE: hdl/esb_dp.sv
// Datapath of the EDF slack packet buffer: two RAM banks, scan engine, totals.
// Depends on esb_pkg and esb_ram; commanded by esb_ctrl.
module esb_dp import esb_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  esb_cmd_t    cmd,
	output esb_sts_t    sts,
	input  logic        operation,
	input  logic [7:0]  packet_count,
	input  logic [7:0]  arrival_slack,
	input  logic [15:0] packet_worth,
	input  logic [6:0]  capacity,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  dropped_now,
	output logic        sent_valid,
	output logic [15:0] sent_worth,
	output logic [31:0] total_arrived,
	output logic [31:0] total_dropped,
	output logic [31:0] total_sent,
	output logic [31:0] total_worth
);
	localparam int unsigned AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned OW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned EW = (OW > 7) ? OW : 7;
	localparam int unsigned DW = (OW > 8) ? OW : 8;

	logic                bank_q;
	logic [OW-1:0]       occ_q;
	logic                busy_q;
	pass_mode_t          mode_q;
	logic [AW-1:0]       rd_ptr_q;
	logic [OW-1:0]       left_q;
	logic                p1_q;
	logic [AW-1:0]       p1_idx_q;
	logic [OW-1:0]       wr_n_q;
	logic                min_any_q;
	logic [7:0]          min_slack_q;
	logic [15:0]         min_worth_q;
	logic [AW-1:0]       min_pos_q;
	logic [DW-1:0]       drop_q;
	logic                op_q;
	logic [7:0]          rem_q;
	logic [7:0]          slack_q;
	logic [15:0]         worth_q;
	logic                item_sent_q;
	logic [15:0]         item_worth_q;
	logic [31:0]         arrived_sum_q, dropped_sum_q, sent_sum_q, worth_sum_q;

	logic                we, we_a, we_b;
	logic [AW-1:0]       waddr;
	logic [ENTRY_W-1:0]  wdata, rd_a, rd_b, rdata;
	logic [7:0]          rd_slack, slack_dec;
	logic [15:0]         rd_worth;
	logic [OW:0]         ptr_inc, pos_inc;
	logic [AW-1:0]       ptr_next, rot_first;
	logic                pass_done, keep, better, out_free;

	esb_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_bank_a (
		.clk, .we(we_a), .waddr, .wdata, .raddr(rd_ptr_q), .rdata(rd_a)
	);
	esb_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_bank_b (
		.clk, .we(we_b), .waddr, .wdata, .raddr(rd_ptr_q), .rdata(rd_b)
	);

	assign rdata     = bank_q ? rd_b : rd_a;
	assign rd_slack  = rdata[ENTRY_W-1:16];
	assign rd_worth  = rdata[15:0];
	assign slack_dec = rd_slack - 8'd1;
	assign keep      = (rd_slack > 8'd1);

	assign ptr_inc   = (OW+1)'(rd_ptr_q) + (OW+1)'(1);
	assign ptr_next  = (ptr_inc == (OW+1)'(occ_q)) ? '0 : ptr_inc[AW-1:0];
	assign pos_inc   = (OW+1)'(min_pos_q) + (OW+1)'(1);
	assign rot_first = (pos_inc == (OW+1)'(occ_q)) ? '0 : pos_inc[AW-1:0];

	assign pass_done = busy_q && (left_q == '0) && !p1_q;
	assign better    = !min_any_q ||
	                   ((mode_q == PASS_TICK) ? (slack_dec < min_slack_q)
	                                          : (rd_slack < min_slack_q));
	assign out_free  = !out_valid || !out_stall;

	// Copy passes write the idle bank; appends write the live one.
	always_comb begin
		we    = 1'b0;
		waddr = wr_n_q[AW-1:0];
		wdata = rdata;
		we_a  = 1'b0;
		we_b  = 1'b0;
		if (cmd.put) begin
			waddr = occ_q[AW-1:0];
			wdata = {slack_q, worth_q};
			we_a  = !bank_q;
			we_b  = bank_q;
		end else if (busy_q && p1_q) begin
			if (mode_q == PASS_ROT) begin
				we = 1'b1;
			end else if (mode_q == PASS_TICK && keep) begin
				we    = 1'b1;
				wdata = {slack_dec, rd_worth};
			end
			we_a = we && bank_q;
			we_b = we && !bank_q;
		end
	end

	always_comb begin
		sts.busy     = busy_q;
		sts.rem_zero = (rem_q == 8'd0);
		sts.room     = ((EW)'(occ_q) < (EW)'(capacity)) &&
		               ((OW+1)'(occ_q) < (OW+1)'(QUEUE_DEPTH));
		sts.occ_zero = (occ_q == '0);
		sts.is_tick  = (op_q == OP_TICK);
		sts.out_free = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q        <= 1'b0;
			occ_q         <= '0;
			busy_q        <= 1'b0;
			mode_q        <= PASS_MIN;
			left_q        <= '0;
			p1_q          <= 1'b0;
			arrived_sum_q <= '0;
			dropped_sum_q <= '0;
			sent_sum_q    <= '0;
			worth_sum_q   <= '0;
			out_valid     <= 1'b0;
		end else begin
			if (cmd.load && operation == OP_ARRIVE) begin
				arrived_sum_q <= arrived_sum_q + 32'(packet_count);
			end
			if (cmd.put) begin
				occ_q <= occ_q + OW'(1);
			end
			if (cmd.start_min || cmd.start_tick || cmd.start_rot) begin
				busy_q <= 1'b1;
				mode_q <= cmd.start_min ? PASS_MIN :
				          (cmd.start_tick ? PASS_TICK : PASS_ROT);
				left_q <= cmd.start_rot ? occ_q - OW'(1) : occ_q;
			end else if (busy_q) begin
				// Issue one read a cycle; consume its data in the next cycle, from the registered RAM output.
				p1_q <= (left_q != '0);
				if (left_q != '0) begin
					left_q <= left_q - OW'(1);
				end
				if (pass_done) begin
					busy_q <= 1'b0;
					if (mode_q != PASS_MIN) begin
						bank_q <= !bank_q;
						occ_q  <= wr_n_q;
					end
				end
			end
			if (cmd.send) begin
				sent_sum_q  <= sent_sum_q + 32'd1;
				worth_sum_q <= worth_sum_q + 32'(min_worth_q);
			end
			if (cmd.emit) begin
				dropped_sum_q <= dropped_sum_q + 32'(drop_q);
				out_valid     <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q         <= operation;
			rem_q        <= (operation == OP_ARRIVE) ? packet_count : 8'd0;
			slack_q      <= arrival_slack;
			worth_q      <= packet_worth;
			drop_q       <= '0;
			item_sent_q  <= 1'b0;
			item_worth_q <= 16'd0;
		end
		if (cmd.take) begin
			rem_q <= rem_q - 8'd1;
		end
		if (cmd.drop) begin
			drop_q <= drop_q + DW'(1);
		end
		if (cmd.send) begin
			item_sent_q  <= 1'b1;
			item_worth_q <= min_worth_q;
		end
		if (cmd.start_min || cmd.start_tick || cmd.start_rot) begin
			rd_ptr_q <= cmd.start_rot ? rot_first : '0;
			wr_n_q   <= '0;
			if (!cmd.start_rot) begin
				min_any_q <= 1'b0;
			end
		end else if (busy_q) begin
			if (left_q != '0) begin
				rd_ptr_q <= ptr_next;
				p1_idx_q <= rd_ptr_q;
			end
			if (p1_q) begin
				case (mode_q)
					PASS_MIN: begin
						if (better) begin
							min_any_q   <= 1'b1;
							min_slack_q <= rd_slack;
							min_worth_q <= rd_worth;
							min_pos_q   <= p1_idx_q;
						end
					end
					PASS_ROT: begin
						wr_n_q <= wr_n_q + OW'(1);
					end
					PASS_TICK: begin
						if (keep) begin
							wr_n_q <= wr_n_q + OW'(1);
							if (better) begin
								min_any_q   <= 1'b1;
								min_slack_q <= slack_dec;
								min_worth_q <= rd_worth;
								min_pos_q   <= wr_n_q[AW-1:0];
							end
						end else begin
							drop_q <= drop_q + DW'(1);
						end
					end
					default: begin
						wr_n_q <= wr_n_q;
					end
				endcase
			end
		end
		if (cmd.emit) begin
			dropped_now   <= drop_q[7:0];
			sent_valid    <= item_sent_q;
			sent_worth    <= item_worth_q;
			total_arrived <= arrived_sum_q;
			total_dropped <= dropped_sum_q + 32'(drop_q);
			total_sent    <= sent_sum_q;
			total_worth   <= worth_sum_q;
		end
	end

`ifndef SYNTHESIS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(OW+1)'(occ_q) <= (OW+1)'(QUEUE_DEPTH))
		else $error("occupancy above depth");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !(cmd.start_min || cmd.start_rot || cmd.start_tick))
		else $error("scan started while busy");
	a_put_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |-> !busy_q && (occ_q != OW'(QUEUE_DEPTH)))
		else $error("append during scan or into full bank");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid && out_stall))
		else $error("result overwritten while stalled");
	a_rot_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_rot |-> occ_q != '0)
		else $error("removal from empty buffer");
`endif
endmodule

FILE: sim/edf_slack_packet_buffer_unit_tb.sv
// Self-checking bench for edf_slack_packet_buffer_unit: random and directed items,
// with the capacity written over APB, checked against an EDF buffer tracker.
// Depends on esb_pkg and the edf_slack_packet_buffer_unit RTL.
module edf_slack_packet_buffer_unit_tb;
	import esb_pkg::*;

	localparam int unsigned DEPTH     = DEPTH_DEFAULT;
	localparam logic [2:0]  CAP_ADDR  = 3'(REG_CAPACITY) * 3'd4;
	localparam int unsigned CYCLE_CAP = 6000000;

	typedef struct {
		logic [7:0]  dropped_now;
		logic        sent_valid;
		logic [15:0] sent_worth;
		logic [31:0] total_arrived;
		logic [31:0] total_dropped;
		logic [31:0] total_sent;
		logic [31:0] total_worth;
	} edf_result_t;

	// Tracks the buffer contents in list order and predicts one result per item.
	class edf_buffer_tracker;
		logic [7:0]  slack_q[$];
		logic [15:0] worth_q[$];
		int unsigned cap_limit = 64;
		logic [31:0] arrived_sum = '0, dropped_sum = '0, sent_sum = '0, worth_sum = '0;
		edf_result_t due_results[$];
		int unsigned mismatches;

		function void set_capacity(logic [6:0] value);
			cap_limit = (value > DEPTH) ? DEPTH : value;
		endfunction

		function int unsigned occupancy();
			return slack_q.size();
		endfunction

		function int unsigned outstanding();
			return due_results.size();
		endfunction

		function int unsigned first_min_slot();
			int unsigned best;
			best = 0;
			for (int unsigned i = 1; i < slack_q.size(); i++)
				if (slack_q[i] < slack_q[best]) best = i;
			return best;
		endfunction

		// Remove the entry at pos; the list restarts right after it.
		function void remove_rotate(int unsigned pos);
			logic [7:0]  s_tmp[$];
			logic [15:0] w_tmp[$];
			for (int unsigned i = pos + 1; i < slack_q.size(); i++) begin
				s_tmp.push_back(slack_q[i]);
				w_tmp.push_back(worth_q[i]);
			end
			for (int unsigned i = 0; i < pos; i++) begin
				s_tmp.push_back(slack_q[i]);
				w_tmp.push_back(worth_q[i]);
			end
			slack_q = s_tmp;
			worth_q = w_tmp;
		endfunction

		function void note_item(logic op, logic [7:0] count, logic [7:0] slack,
				logic [15:0] worth);
			edf_result_t r;
			int unsigned dropped;
			logic [7:0]  s_tmp[$];
			logic [15:0] w_tmp[$];
			dropped = 0;
			r.sent_valid = 1'b0;
			r.sent_worth = '0;
			if (op == OP_ARRIVE) begin
				arrived_sum += 32'(count);
				for (int unsigned k = 0; k < count; k++) begin
					if (slack_q.size() < cap_limit) begin
						slack_q.push_back(slack);
						worth_q.push_back(worth);
					end else begin
						dropped++;
						if (slack_q.size() > 0) begin
							remove_rotate(first_min_slot());
							slack_q.push_back(slack);
							worth_q.push_back(worth);
						end
					end
				end
			end else begin
				foreach (slack_q[i]) begin
					if (slack_q[i] > 1) begin
						s_tmp.push_back(slack_q[i] - 8'd1);
						w_tmp.push_back(worth_q[i]);
					end else begin
						dropped++;
					end
				end
				slack_q = s_tmp;
				worth_q = w_tmp;
				if (slack_q.size() > 0) begin
					int unsigned pos;
					pos = first_min_slot();
					r.sent_valid = 1'b1;
					r.sent_worth = worth_q[pos];
					remove_rotate(pos);
					sent_sum += 32'd1;
					worth_sum += 32'(r.sent_worth);
				end
			end
			dropped_sum += 32'(dropped);
			r.dropped_now = dropped[7:0];
			r.total_arrived = arrived_sum;
			r.total_dropped = dropped_sum;
			r.total_sent = sent_sum;
			r.total_worth = worth_sum;
			due_results.push_back(r);
		endfunction

		function void field_check(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (exp_v !== act_v) begin
				mismatches++;
				$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
			end
		endfunction

		function void check_result(edf_result_t act);
			edf_result_t e;
			if (due_results.size() == 0) begin
				mismatches++;
				$display("%0t: result with none expected: expected nothing, got dropped %0d",
					$time, act.dropped_now);
				return;
			end
			e = due_results.pop_front();
			field_check("dropped_now", 32'(e.dropped_now), 32'(act.dropped_now));
			field_check("sent_valid", 32'(e.sent_valid), 32'(act.sent_valid));
			field_check("sent_worth", 32'(e.sent_worth), 32'(act.sent_worth));
			field_check("total_arrived", e.total_arrived, act.total_arrived);
			field_check("total_dropped", e.total_dropped, act.total_dropped);
			field_check("total_sent", e.total_sent, act.total_sent);
			field_check("total_worth", e.total_worth, act.total_worth);
		endfunction
	endclass

	logic        clk, arst_n;
	logic        in_valid, in_stall, operation;
	logic [7:0]  packet_count, arrival_slack;
	logic [15:0] packet_worth;
	logic        out_valid, out_stall;
	logic [7:0]  dropped_now;
	logic        sent_valid;
	logic [15:0] sent_worth;
	logic [31:0] total_arrived, total_dropped, total_sent, total_worth;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;

	edf_buffer_tracker tracker;
	bit          no_idle;        // while set, neither side idles
	int unsigned hold_cycles;    // receiver hold-off requested by the stimulus
	int unsigned cycle_count;

	edf_slack_packet_buffer_unit dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bound the run; a hang ends in failure.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_CAP) begin
				$display("FAIL edf_slack_packet_buffer_unit");
				$finish;
			end
		end
	end

	// Receiver: check each accepted result, stall at random or on request.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				tracker.check_result('{dropped_now, sent_valid, sent_worth, total_arrived,
					total_dropped, total_sent, total_worth});
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !no_idle && ($urandom_range(99) < 22);
			end
		end
	end

	// Write the capacity over APB: setup cycle, then access until pready.
	task automatic write_capacity(logic [6:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CAP_ADDR;
		pwdata  <= {$urandom_range(1) ? 25'h1ffffff : 25'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.set_capacity(value);
	endtask

	// Offer one item, hold it until accepted, then idle at random.
	task automatic push_item(logic op, logic [7:0] count, logic [7:0] slack,
			logic [15:0] worth);
		in_valid      <= 1'b1;
		operation     <= op;
		packet_count  <= count;
		arrival_slack <= slack;
		packet_worth  <= worth;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tracker.note_item(op, count, slack, worth);
		if (!no_idle && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Drop valid and wait for every expected result, plus a short settle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.outstanding() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_items(int unsigned n);
		logic [7:0] count, slack;
		int unsigned pick;
		repeat (n) begin
			pick = $urandom_range(99);
			count = (pick < 85) ? 8'($urandom_range(0, 6)) :
				(pick < 98) ? 8'($urandom_range(0, 40)) : 8'($urandom_range(0, 255));
			slack = ($urandom_range(99) < 70) ? 8'($urandom_range(0, 12)) :
				8'($urandom_range(0, 255));
			push_item(($urandom_range(99) < 40) ? OP_TICK : OP_ARRIVE, count, slack,
				16'($urandom));
		end
	endtask

	initial begin
		logic [6:0] cap_plan[8] = '{7'd127, 7'd1, 7'd0, 7'd7, 7'd64, 7'd33, 7'd100, 7'd2};
		tracker       = new();
		no_idle       = 1'b0;
		hold_cycles   = 0;
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		operation     <= OP_ARRIVE;
		packet_count  <= '0;
		arrival_slack <= '0;
		packet_worth  <= '0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty tick, zero count, field extremes, zero slack, overflow.
		push_item(OP_TICK, 8'd0, 8'd0, 16'd0);
		push_item(OP_ARRIVE, 8'd0, 8'd255, 16'hffff);
		push_item(OP_ARRIVE, 8'd1, 8'd0, 16'd0);
		push_item(OP_ARRIVE, 8'd1, 8'd255, 16'hffff);
		push_item(OP_TICK, 8'd255, 8'd255, 16'hffff);
		push_item(OP_ARRIVE, 8'd3, 8'd1, 16'h5a5a);
		push_item(OP_ARRIVE, 8'd2, 8'd2, 16'ha5a5);
		push_item(OP_TICK, 8'd0, 8'd0, 16'd0);
		push_item(OP_ARRIVE, 8'd70, 8'd9, 16'h1234);
		push_item(OP_ARRIVE, 8'd255, 8'd4, 16'h8001);
		push_item(OP_ARRIVE, 8'd5, 8'd0, 16'h7ffe);
		repeat (4) push_item(OP_TICK, 8'd0, 8'd0, 16'd0);
		drain();

		foreach (cap_plan[p]) begin
			// Capacity zero only matters with an empty buffer: tick it dry first.
			if (cap_plan[p] == 7'd0) begin
				while (tracker.occupancy() > 0) push_item(OP_TICK, 8'd0, 8'd0, 16'd0);
				drain();
			end
			write_capacity(cap_plan[p]);
			no_idle = (p == 4);
			if (p == 2) hold_cycles = 400;  // back up the block until it stalls input
			random_items(66);
			drain();
		end

		repeat (100) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.outstanding() == 0)
			$display("PASS edf_slack_packet_buffer_unit");
		else
			$display("FAIL edf_slack_packet_buffer_unit");
		$finish;
	end
endmodule

FILE: edf_slack_packet_buffer_unit.f
hdl/esb_pkg.sv
hdl/esb_ram.sv
hdl/esb_ctrl.sv
hdl/esb_dp.sv
hdl/edf_slack_packet_buffer_unit.sv
sim/edf_slack_packet_buffer_unit_tb.sv
